### src/tksl_pkg.sv
// Shared types and constants for the bounded top-k insertion list.
package tksl_pkg;

   localparam int MAX_ENTRIES = 50;
   localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int CMP_W = CNT_W + 1;

   localparam int FUNC_W = 2;
   localparam int SCORE_W = 6;
   localparam int RANK_W = 24;
   localparam int ID_W = 20;
   localparam int POS_W = 6;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_OFFER = 2'd0,
      FUNC_READ  = 2'd1,
      FUNC_CLEAR = 2'd2
   } func_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_ROTATE
   } cell_op_type;

   typedef enum logic {
      ST_IDLE,
      ST_READ
   } state_type;

   typedef struct packed {
      logic [FUNC_W-1:0]  func;
      logic [SCORE_W-1:0] score;
      logic [RANK_W-1:0]  player_rank;
      logic [ID_W-1:0]    entry_id;
   } req_type;

   typedef struct packed {
      logic               entry_valid;
      logic [ID_W-1:0]    out_id;
      logic [SCORE_W-1:0] out_score;
      logic [RANK_W-1:0]  out_rank;
      logic [POS_W-1:0]   position;
      logic               accepted;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic [ID_W-1:0]    id;
      logic [SCORE_W-1:0] score;
      logic [RANK_W-1:0]  rank;
   } entry_type;

   typedef struct packed {
      cell_op_type       op;
      entry_type         new_entry;
      logic [CNT_W-1:0]  fill;
   } cell_cmd_type;

   typedef struct packed {
      entry_type         head;
      logic [IDX_W-1:0]  pos;
      logic              room;
   } chain_stat_type;

endpackage

### src/tksl_cell.sv
// One list cell: holds an entry, compares it with the offered one, shifts or rotates.
module tksl_cell (
   input  logic                       clock,
   input  tksl_pkg::cell_cmd_type     cmd,
   input  logic [tksl_pkg::IDX_W-1:0] cell_idx,
   input  tksl_pkg::entry_type        prev_entry,
   input  logic                       prev_good,
   input  tksl_pkg::entry_type        next_entry,
   input  tksl_pkg::entry_type        head_entry,
   output tksl_pkg::entry_type        entry,
   output logic                       good
);

   tksl_pkg::entry_type entry_ff;
   tksl_pkg::entry_type entry_in;
   logic [tksl_pkg::CMP_W-1:0] idx_ext;
   logic [tksl_pkg::CMP_W-1:0] fill_ext;
   logic occupied;
   logic is_tail;
   logic better;

   assign idx_ext  = tksl_pkg::CMP_W'(cell_idx);
   assign fill_ext = tksl_pkg::CMP_W'(cmd.fill);
   assign occupied = idx_ext < fill_ext;
   assign is_tail  = (idx_ext + tksl_pkg::CMP_W'(1)) == fill_ext;

   // stored entry at least as good as the offered one
   assign better = (entry_ff.score > cmd.new_entry.score) ||
                   ((entry_ff.score == cmd.new_entry.score) &&
                    (entry_ff.rank <= cmd.new_entry.rank));
   assign good  = occupied & better;
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      case (cmd.op)
         tksl_pkg::CELL_INSERT: begin
            if (good) begin
               entry_in = entry_ff;
            end else if (prev_good) begin
               entry_in = cmd.new_entry;
            end else begin
               entry_in = prev_entry;
            end
         end
         tksl_pkg::CELL_ROTATE: begin
            // wrap the head around to the last occupied cell
            entry_in = is_tail ? head_entry : next_entry;
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

### src/tksl_chain.sv
// Row of list cells with insert position encoding.
module tksl_chain (
   input  logic                       clock,
   input  tksl_pkg::cell_cmd_type     cmd,
   output tksl_pkg::chain_stat_type   stat
);

   tksl_pkg::entry_type entries [tksl_pkg::MAX_ENTRIES];
   logic [tksl_pkg::MAX_ENTRIES-1:0] goods;
   logic [tksl_pkg::MAX_ENTRIES-1:0] prev_goods;
   logic [tksl_pkg::IDX_W-1:0] pos;

   for (genvar k = 0; k < tksl_pkg::MAX_ENTRIES; k++) begin : g_cell
      tksl_pkg::entry_type prev_e;
      tksl_pkg::entry_type next_e;

      if (k == 0) begin : g_first
         assign prev_e = cmd.new_entry;
         assign prev_goods[k] = 1'b1;
      end else begin : g_rest
         assign prev_e = entries[k-1];
         assign prev_goods[k] = goods[k-1];
      end

      if (k == tksl_pkg::MAX_ENTRIES - 1) begin : g_end
         assign next_e = entries[k];
      end else begin : g_mid
         assign next_e = entries[k+1];
      end

      tksl_cell u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .cell_idx   (tksl_pkg::IDX_W'(k)),
         .prev_entry (prev_e),
         .prev_good  (prev_goods[k]),
         .next_entry (next_e),
         .head_entry (entries[0]),
         .entry      (entries[k]),
         .good       (goods[k])
      );
   end

   // goods is a run of ones from cell 0; the insert point is the first zero
   always_comb begin
      pos = '0;
      for (int k = 0; k < tksl_pkg::MAX_ENTRIES; k++) begin
         if (!goods[k] && prev_goods[k]) begin
            pos = pos | tksl_pkg::IDX_W'(k);
         end
      end
   end

   assign stat.head = entries[0];
   assign stat.pos  = pos;
   assign stat.room = ~goods[tksl_pkg::MAX_ENTRIES-1];

endmodule

### src/top_k_sorted_insert_list.sv
// Top level of the bounded top-k insertion list: command decode, read sequencer, output register.
//
// Requests arrive on req_valid/req_stall with req_data (func, score, player_rank,
// entry_id); results leave on rsp_valid/rsp_stall with rsp_data.
// An offer compares the new entry against every cell of the list at once and
// shifts the worse cells down by one in the same cycle, so offers can follow
// each other every cycle while the receiver does not stall. Its one result appears
// in the output register the cycle after the request is taken.
// A read out rotates the list through cell 0, one entry per cycle while the
// receiver does not stall, and gives one result per stored entry (or a single
// empty result); the list returns to its original order after the last entry.
// New requests are held off until the read out ends; receiver stalls add to this.
// A clear empties the list and gives no result.
// Reset empties the list and drops any pending result.
// While rsp_stall is high and a result is pending, it holds and no new request is taken.
module top_k_sorted_insert_list (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  tksl_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output tksl_pkg::rsp_type rsp_data
);

   tksl_pkg::state_type state_ff, state_in;
   logic [tksl_pkg::CNT_W-1:0] fill_ff, fill_in;
   logic [tksl_pkg::IDX_W-1:0] rd_idx_ff, rd_idx_in;
   logic rsp_valid_ff, rsp_valid_in;
   tksl_pkg::rsp_type rsp_data_ff, rsp_data_in;

   tksl_pkg::cell_cmd_type cmd;
   tksl_pkg::chain_stat_type stat;
   logic out_free;
   logic req_take;
   logic load_out;
   logic rd_last;

   assign out_free = ~rsp_valid_ff | ~rsp_stall;
   assign req_stall = (state_ff != tksl_pkg::ST_IDLE) | ~out_free;
   assign req_take = req_valid & ~req_stall;
   assign rd_last = (tksl_pkg::CMP_W'(rd_idx_ff) + tksl_pkg::CMP_W'(1)) ==
                    tksl_pkg::CMP_W'(fill_ff);

   tksl_chain u_chain (
      .clock (clock),
      .cmd   (cmd),
      .stat  (stat)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tksl_pkg::ST_IDLE: begin
            if (req_take && (req_data.func == tksl_pkg::FUNC_READ) && (fill_ff != '0)) begin
               state_in = tksl_pkg::ST_READ;
            end
         end
         tksl_pkg::ST_READ: begin
            if (out_free && rd_last) begin
               state_in = tksl_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tksl_pkg::ST_IDLE;
         end
      endcase
   end

   // outputs and datapath control
   always_comb begin
      cmd.op = tksl_pkg::CELL_HOLD;
      cmd.new_entry.id = req_data.entry_id;
      cmd.new_entry.score = req_data.score;
      cmd.new_entry.rank = req_data.player_rank;
      cmd.fill = fill_ff;
      fill_in = fill_ff;
      rd_idx_in = rd_idx_ff;
      load_out = 1'b0;
      rsp_data_in = '0;
      rsp_data_in.last = 1'b1;
      case (state_ff)
         tksl_pkg::ST_IDLE: begin
            rd_idx_in = '0;
            if (req_take) begin
               case (req_data.func)
                  tksl_pkg::FUNC_OFFER: begin
                     load_out = 1'b1;
                     rsp_data_in.out_id = req_data.entry_id;
                     rsp_data_in.out_score = req_data.score;
                     rsp_data_in.out_rank = req_data.player_rank;
                     if ((req_data.score != '0) && stat.room) begin
                        cmd.op = tksl_pkg::CELL_INSERT;
                        rsp_data_in.entry_valid = 1'b1;
                        rsp_data_in.accepted = 1'b1;
                        rsp_data_in.position = tksl_pkg::POS_W'(stat.pos);
                        if (fill_ff != tksl_pkg::CNT_W'(tksl_pkg::MAX_ENTRIES)) begin
                           fill_in = fill_ff + tksl_pkg::CNT_W'(1);
                        end
                     end
                  end
                  tksl_pkg::FUNC_READ: begin
                     // empty list: one all-zero result
                     load_out = (fill_ff == '0);
                  end
                  tksl_pkg::FUNC_CLEAR: begin
                     fill_in = '0;
                  end
                  default: begin
                     fill_in = fill_ff;
                  end
               endcase
            end
         end
         tksl_pkg::ST_READ: begin
            if (out_free) begin
               load_out = 1'b1;
               cmd.op = tksl_pkg::CELL_ROTATE;
               rsp_data_in.entry_valid = 1'b1;
               rsp_data_in.out_id = stat.head.id;
               rsp_data_in.out_score = stat.head.score;
               rsp_data_in.out_rank = stat.head.rank;
               rsp_data_in.position = tksl_pkg::POS_W'(rd_idx_ff);
               rsp_data_in.last = rd_last;
               rd_idx_in = rd_idx_ff + tksl_pkg::IDX_W'(1);
            end
         end
         default: begin
            rd_idx_in = '0;
         end
      endcase
   end

   always_comb begin
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tksl_pkg::ST_IDLE;
         fill_ff <= '0;
         rd_idx_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff <= fill_in;
         rd_idx_ff <= rd_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

endmodule

### src/tksl_checker.sv
// Port-level checks for the top-k insertion list, bound to the top level.
module tksl_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input tksl_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input tksl_pkg::rsp_type rsp_data
);

   a_reset_drops_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   a_offer_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_data.func == tksl_pkg::FUNC_OFFER) |=>
      rsp_valid && rsp_data.last && (rsp_data.out_id == $past(req_data.entry_id)))
      else $error("offer did not give its single result");

   a_accept_marks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.accepted |->
      rsp_data.entry_valid && rsp_data.last && (rsp_data.out_score != '0))
      else $error("accepted result malformed");

   a_entry_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.entry_valid |-> (rsp_data.out_score != '0))
      else $error("list entry with zero score");

endmodule

bind top_k_sorted_insert_list tksl_checker u_checker (.*);

### tb/sv/tb_top_k_sorted_insert_list.sv
// Testbench for the top-k insertion list: directed table plus random requests with a predictor.
module tb_top_k_sorted_insert_list;

   localparam logic [tksl_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;
   localparam int PHASE_ITEMS = 98;
   localparam int HOLD_AT = 70;
   localparam int HOLD_CYCLES = 300;
   localparam int DRAIN_CYCLES = tksl_pkg::MAX_ENTRIES + 20;
   localparam int CYCLE_LIMIT = 500000;
   localparam int PRINT_CAP = 40;

   localparam tksl_pkg::rsp_type NO_RSP = '0;
   localparam tksl_pkg::rsp_type EMPTY_READ = '{1'b0, 20'h0, 6'd0, 24'h0, 6'd0, 1'b0, 1'b1};

   typedef struct {
      tksl_pkg::req_type req;
      bit                typed;
      tksl_pkg::rsp_type rsp;
   } table_row_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   tksl_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   tksl_pkg::rsp_type rsp_data;

   // typed expectation travels with the request it belongs to
   bit                req_is_typed = 1'b0;
   tksl_pkg::rsp_type req_typed_rsp = '0;

   tksl_pkg::entry_type list_cells [tksl_pkg::MAX_ENTRIES];
   int                  list_fill = 0;
   tksl_pkg::rsp_type   step_rsps [$];
   tksl_pkg::rsp_type   list_rsps_due [$];
   table_row_type       directed_rows [$];

   int fail_count = 0;
   int cycle_count = 0;
   int requests_taken = 0;
   int idle_pct = 0;
   int stall_pct = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;

   top_k_sorted_insert_list u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   task automatic report_mismatch(input string msg);
      fail_count++;
      if (fail_count <= PRINT_CAP) begin
         $display("mismatch @%0d: %s", cycle_count, msg);
      end
   endtask

   // Work out the results of one request and advance the list copy.
   function automatic void apply_list_request(input tksl_pkg::req_type r);
      int p;
      int k;
      int top;
      tksl_pkg::rsp_type rsp;
      step_rsps.delete();
      case (r.func)
         tksl_pkg::FUNC_OFFER: begin
            if (r.score == '0) begin
               step_rsps.push_back('{1'b0, r.entry_id, r.score, r.player_rank,
                                     6'd0, 1'b0, 1'b1});
            end else begin
               p = 0;
               while (p < list_fill &&
                      (list_cells[p].score > r.score ||
                       (list_cells[p].score == r.score &&
                        list_cells[p].rank <= r.player_rank))) begin
                  p++;
               end
               if (p >= tksl_pkg::MAX_ENTRIES) begin
                  step_rsps.push_back('{1'b0, r.entry_id, r.score, r.player_rank,
                                        6'd0, 1'b0, 1'b1});
               end else begin
                  // shift worse cells down; the last one drops when full
                  top = (list_fill < tksl_pkg::MAX_ENTRIES) ? list_fill :
                        tksl_pkg::MAX_ENTRIES - 1;
                  for (k = top; k > p; k--) begin
                     list_cells[k] = list_cells[k-1];
                  end
                  list_cells[p] = '{r.entry_id, r.score, r.player_rank};
                  if (list_fill < tksl_pkg::MAX_ENTRIES) begin
                     list_fill++;
                  end
                  step_rsps.push_back('{1'b1, r.entry_id, r.score, r.player_rank,
                                        tksl_pkg::POS_W'(p), 1'b1, 1'b1});
               end
            end
         end
         tksl_pkg::FUNC_READ: begin
            if (list_fill == 0) begin
               step_rsps.push_back(EMPTY_READ);
            end else begin
               for (k = 0; k < list_fill; k++) begin
                  rsp = '{1'b1, list_cells[k].id, list_cells[k].score,
                          list_cells[k].rank, tksl_pkg::POS_W'(k), 1'b0,
                          (k == list_fill - 1)};
                  step_rsps.push_back(rsp);
               end
            end
         end
         tksl_pkg::FUNC_CLEAR: begin
            list_fill = 0;
         end
         default: begin
         end
      endcase
   endfunction

   task automatic check_result(input tksl_pkg::rsp_type want, input tksl_pkg::rsp_type got);
      if (got.entry_valid !== want.entry_valid)
         report_mismatch($sformatf("entry_valid got %0b want %0b",
                                   got.entry_valid, want.entry_valid));
      if (got.out_id !== want.out_id)
         report_mismatch($sformatf("out_id got %h want %h", got.out_id, want.out_id));
      if (got.out_score !== want.out_score)
         report_mismatch($sformatf("out_score got %0d want %0d",
                                   got.out_score, want.out_score));
      if (got.out_rank !== want.out_rank)
         report_mismatch($sformatf("out_rank got %h want %h", got.out_rank, want.out_rank));
      if (got.position !== want.position)
         report_mismatch($sformatf("position got %0d want %0d",
                                   got.position, want.position));
      if (got.accepted !== want.accepted)
         report_mismatch($sformatf("accepted got %0b want %0b",
                                   got.accepted, want.accepted));
      if (got.last !== want.last)
         report_mismatch($sformatf("last got %0b want %0b", got.last, want.last));
   endtask

   // Check the result first: it always belongs to an earlier request.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
            if (list_rsps_due.size() == 0) begin
               report_mismatch($sformatf("result with none due, id %h", rsp_data.out_id));
            end else begin
               check_result(list_rsps_due.pop_front(), rsp_data);
            end
         end
         if (req_valid && req_stall === 1'b0) begin
            apply_list_request(req_data);
            if (req_is_typed) begin
               list_rsps_due.push_back(req_typed_rsp);
            end else begin
               foreach (step_rsps[i]) list_rsps_due.push_back(step_rsps[i]);
            end
            requests_taken++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout with %0d results due", list_rsps_due.size());
         $display("status: fail");
         $finish;
      end
   end

   // Receiver: random stalls plus one long hold-off to fill the block.
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (!hold_done && requests_taken >= HOLD_AT) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_request(input tksl_pkg::req_type r, input bit typed,
                               input tksl_pkg::rsp_type want);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      req_is_typed <= typed;
      req_typed_rsp <= want;
      do @(posedge clock); while (req_stall !== 1'b0);
      @(negedge clock);
   endtask

   task automatic add_row(input logic [tksl_pkg::FUNC_W-1:0] f,
                          input logic [tksl_pkg::SCORE_W-1:0] s,
                          input logic [tksl_pkg::RANK_W-1:0] rk,
                          input logic [tksl_pkg::ID_W-1:0] id,
                          input bit typed, input tksl_pkg::rsp_type want);
      table_row_type row;
      row.req = '{f, s, rk, id};
      row.typed = typed;
      row.rsp = want;
      directed_rows.push_back(row);
   endtask

   function automatic tksl_pkg::req_type random_request();
      tksl_pkg::req_type r;
      int pick;
      int mode;
      r.entry_id = tksl_pkg::ID_W'($urandom);
      r.player_rank = tksl_pkg::RANK_W'($urandom);
      r.score = tksl_pkg::SCORE_W'($urandom_range(63, 1));
      mode = $urandom_range(99);
      if (mode < 6) begin
         r.score = '0;
      end else if (mode < 36) begin
         // crowd a few scores and ranks to force ties
         r.score = tksl_pkg::SCORE_W'($urandom_range(3, 1));
         r.player_rank = tksl_pkg::RANK_W'($urandom_range(7));
      end else if (mode < 50) begin
         r.score = $urandom_range(1) ? 6'd63 : 6'd1;
         r.player_rank = $urandom_range(1) ? 24'hFFFFFF : 24'h0;
      end
      pick = $urandom_range(99);
      if (pick < 1) r.func = tksl_pkg::FUNC_CLEAR;
      else if (pick < 3) r.func = FUNC_UNUSED;
      else if (pick < 10) r.func = tksl_pkg::FUNC_READ;
      else r.func = tksl_pkg::FUNC_OFFER;
      return r;
   endfunction

   initial begin
      tksl_pkg::req_type r;
      int idle_by_phase [4];
      int stall_by_phase [4];
      idle_by_phase = '{0, 52, 0, 34};
      stall_by_phase = '{0, 0, 52, 34};

      add_row(tksl_pkg::FUNC_READ,  6'd0,  24'h0,      20'h0,     1, EMPTY_READ);
      add_row(tksl_pkg::FUNC_OFFER, 6'd0,  24'hFFFFFF, 20'hFFFFF, 1,
              '{1'b0, 20'hFFFFF, 6'd0, 24'hFFFFFF, 6'd0, 1'b0, 1'b1});
      add_row(tksl_pkg::FUNC_OFFER, 6'd63, 24'h0,      20'h0,     1,
              '{1'b1, 20'h0, 6'd63, 24'h0, 6'd0, 1'b1, 1'b1});
      add_row(tksl_pkg::FUNC_OFFER, 6'd63, 24'h0,      20'h1,     0, NO_RSP);
      add_row(tksl_pkg::FUNC_OFFER, 6'd63, 24'hFFFFFF, 20'h2,     0, NO_RSP);
      add_row(tksl_pkg::FUNC_OFFER, 6'd1,  24'hFFFFFF, 20'hFFFFF, 0, NO_RSP);
      add_row(tksl_pkg::FUNC_OFFER, 6'd1,  24'h0,      20'h3,     0, NO_RSP);
      add_row(tksl_pkg::FUNC_OFFER, 6'd32, 24'h123456, 20'h55555, 0, NO_RSP);
      add_row(tksl_pkg::FUNC_OFFER, 6'd0,  24'h0,      20'h0,     1,
              '{1'b0, 20'h0, 6'd0, 24'h0, 6'd0, 1'b0, 1'b1});
      add_row(tksl_pkg::FUNC_READ,  6'd63, 24'hFFFFFF, 20'hFFFFF, 0, NO_RSP);
      add_row(FUNC_UNUSED,          6'd63, 24'hFFFFFF, 20'hFFFFF, 0, NO_RSP);
      add_row(tksl_pkg::FUNC_CLEAR, 6'd17, 24'h0F0F0F, 20'h0F0F0, 0, NO_RSP);
      add_row(tksl_pkg::FUNC_READ,  6'd0,  24'h0,      20'h0,     1, EMPTY_READ);
      add_row(tksl_pkg::FUNC_OFFER, 6'h2A, 24'hAAAAAA, 20'hAAAAA, 1,
              '{1'b1, 20'hAAAAA, 6'h2A, 24'hAAAAAA, 6'd0, 1'b1, 1'b1});
      add_row(tksl_pkg::FUNC_OFFER, 6'h15, 24'h555555, 20'h55555, 0, NO_RSP);
      add_row(tksl_pkg::FUNC_OFFER, 6'h2A, 24'hAAAAAA, 20'h12345, 0, NO_RSP);
      add_row(tksl_pkg::FUNC_READ,  6'd0,  24'h0,      20'h0,     0, NO_RSP);
      add_row(tksl_pkg::FUNC_CLEAR, 6'd0,  24'h0,      20'h0,     0, NO_RSP);

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].rsp);
      end

      for (int ph = 0; ph < 4; ph++) begin
         idle_pct = idle_by_phase[ph];
         stall_pct = stall_by_phase[ph];
         // start each phase from an empty list so it fills and overflows
         r = random_request();
         r.func = tksl_pkg::FUNC_CLEAR;
         send_request(r, 1'b0, NO_RSP);
         for (int n = 1; n < PHASE_ITEMS; n++) begin
            send_request(random_request(), 1'b0, NO_RSP);
         end
      end
      req_valid <= 1'b0;
      idle_pct = 0;

      while (list_rsps_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (list_rsps_due.size() != 0) begin
         report_mismatch($sformatf("%0d results never arrived", list_rsps_due.size()));
      end

      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

### files.f
src/tksl_pkg.sv
src/tksl_cell.sv
src/tksl_chain.sv
src/top_k_sorted_insert_list.sv
src/tksl_checker.sv
tb/sv/tb_top_k_sorted_insert_list.sv
